// ===== hdl/cacfar_pkg.sv =====
// Shared types and constants for the cell-averaging CFAR detector.
// Depends on nothing; every other file but the window RAM imports it.
`default_nettype none

package cacfar_pkg;

    localparam int SAMPLE_W   = 16;  // I and Q sample width
    localparam int POWER_W    = 32;  // I*I + Q*Q, exact
    localparam int SCALE_W    = 32;  // Q16.16 threshold factor
    localparam int FRAC_W     = 16;  // fraction bits of the factor
    localparam int MUL_W      = 32;  // split point of the wide product
    localparam int INDEX_W    = 16;  // reported cell index
    localparam int GUARD_W    = 4;
    localparam int TRAIN_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [GUARD_W-1:0] GUARD_RST = 4'd2;
    localparam logic [TRAIN_W-1:0] TRAIN_RST = 6'd8;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GUARD = 2'd0,
        REG_TRAIN = 2'd1,
        REG_SCALE = 2'd2
    } cfg_reg_t;

    // Status returned by the threshold unit.
    typedef struct packed {
        logic done;
        logic hit;
    } thr_res_t;

endpackage

`default_nettype wire

// ===== hdl/cacfar_window_ram.sv =====
// Power window store: one write port and one read port, registered read data.
// Standalone; no package needed.
`default_nettype none

module cacfar_window_ram #(
    parameter int DEPTH  = 81,
    parameter int DATA_W = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] window_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            window_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= window_mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/cacfar_threshold.sv =====
// Exact threshold test cut * cnt * 2^16 > sum * scale, five register stages.
// Depends on cacfar_pkg.
`default_nettype none

module cacfar_threshold
    import cacfar_pkg::*;
#(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [POWER_W-1:0] cut,
    input  wire logic [CNT_W-1:0]   cnt,
    input  wire logic [SUM_W-1:0]   sum,
    input  wire logic [SCALE_W-1:0] scale,
    output thr_res_t                res
);

    localparam int LO_PROD_W = MUL_W + SCALE_W;
    localparam int HI_W      = SUM_W - MUL_W;
    localparam int HI_PROD_W = HI_W + SCALE_W;
    localparam int PROD_W    = SUM_W + SCALE_W;
    localparam int LEFT_W    = POWER_W + CNT_W;
    localparam int LHS_W     = LEFT_W + FRAC_W;
    localparam int CMP_W     = (PROD_W > LHS_W) ? PROD_W : LHS_W;

    logic                 v0_reg, v1_reg, v2_reg, v3_reg, done_reg;
    logic [POWER_W-1:0]   cut_op_reg;
    logic [CNT_W-1:0]     cnt_op_reg;
    logic [SUM_W-1:0]     sum_op_reg;
    logic [SCALE_W-1:0]   scale_op_reg;
    logic [LO_PROD_W-1:0] p_lo_reg;
    logic [HI_PROD_W-1:0] p_hi_reg;
    logic [LEFT_W-1:0]    left_reg;
    logic [PROD_W-1:0]    rhs_reg;
    logic                 hit_reg;
    logic [LHS_W-1:0]     lhs;

    assign lhs = {left_reg, {FRAC_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Only one transaction is in flight, so each stage may read the
    // registers of any earlier stage.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cut_op_reg   <= cut;
            cnt_op_reg   <= cnt;
            sum_op_reg   <= sum;
            scale_op_reg <= scale;
        end
        if (v0_reg)
        begin
            p_lo_reg <= LO_PROD_W'(sum_op_reg[MUL_W-1:0]) * LO_PROD_W'(scale_op_reg);
            left_reg <= LEFT_W'(cut_op_reg) * LEFT_W'(cnt_op_reg);
        end
        if (v1_reg)
        begin
            p_hi_reg <= HI_PROD_W'(sum_op_reg[SUM_W-1:MUL_W]) * HI_PROD_W'(scale_op_reg);
        end
        if (v2_reg)
        begin
            rhs_reg <= {p_hi_reg, {MUL_W{1'b0}}} + PROD_W'(p_lo_reg);
        end
        if (v3_reg)
        begin
            hit_reg <= CMP_W'(lhs) > CMP_W'(rhs_reg);
        end
    end

    assign res.done = done_reg;
    assign res.hit  = hit_reg;

`ifndef ASSERT_OFF
    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == $past(start, 5))
        else $error("threshold result not five cycles after start");

    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({v0_reg, v1_reg, v2_reg, v3_reg, done_reg}))
        else $error("more than one transaction in the threshold unit");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !(v0_reg || v1_reg || v2_reg || v3_reg || done_reg))
        else $error("threshold unit started while busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/cell_averaging_cfar_detector.sv =====
// Cell-averaging CFAR detector top level: sequencer, power window, threshold unit and output register.
// Depends on cacfar_pkg, cacfar_window_ram and cacfar_threshold.
// A sample whose window is incomplete is only written to it. For an evaluated cell, the
// window RAM's single read port fetches the cell under test and the 2T training cells
// one at a time. No new sample is taken until the cell and any detection are done.
// Reset (asynchronous, active low) restores the registers' defaults and empties the frame.
`default_nettype none

module cell_averaging_cfar_detector
    import cacfar_pkg::*;
#(
    parameter int MAX_GUARD = 8,
    parameter int MAX_TRAIN = 32,
    parameter int MAX_FRAME = 65536
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_i,
    input  wire logic signed [SAMPLE_W-1:0] sample_q,
    input  wire logic                       frame_end,
    // Output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [INDEX_W-1:0]              cell_index,
    // Configuration write port
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    // The window holds the last 2*(G+T)+1 powers at the largest settings.
    localparam int WIN_DEPTH = 2 * (MAX_GUARD + MAX_TRAIN) + 1;
    localparam int AGE_W     = $clog2(WIN_DEPTH);
    localparam int WW        = $clog2(WIN_DEPTH + 1);
    localparam int XW        = (WW > TRAIN_W) ? WW : TRAIN_W;
    localparam int AS_W      = WW + 1;
    localparam int CW        = $clog2(MAX_FRAME);
    localparam int CMP_W     = ((CW > WW) ? CW : WW) + 1;
    localparam int IDX_W     = (CMP_W > INDEX_W) ? CMP_W : INDEX_W;
    localparam int J_W       = $clog2(2 * MAX_TRAIN + 1);
    localparam int SUM_W     = POWER_W + 1 + $clog2(MAX_TRAIN);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WRITE = 6'b000010,
        ST_READ  = 6'b000100,
        ST_LAST  = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. The user must see that they are only written
    // while the block is idle, so the derived window geometry below is stable
    // for the whole of one transaction; the block itself does not enforce it.
    // ------------------------------------------------------------------
    logic [GUARD_W-1:0] guard_count_reg;
    logic [TRAIN_W-1:0] train_count_reg;
    logic [SCALE_W-1:0] scale_factor_reg;

    // Control state
    state_t             state_reg;
    logic [AGE_W-1:0]   wp_reg;
    logic [CW-1:0]      counter_reg;
    logic [J_W-1:0]     j_reg;
    logic               eval_reg;
    logic               acc_en_reg;
    logic               cut_en_reg;
    logic               out_valid_reg;

    // Payload registers
    logic [POWER_W-1:0] sq_i_reg;
    logic [POWER_W-1:0] sq_q_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [POWER_W-1:0] cut_reg;
    logic [INDEX_W-1:0] cell_index_reg;

    // Combinational helpers
    logic [WW-1:0]       g;
    logic [WW-1:0]       t;
    logic [WW-1:0]       span;
    logic [WW-1:0]       win;
    logic [J_W-1:0]      two_t;
    logic [WW-1:0]       j_w;
    logic [WW-1:0]       age;
    logic [AS_W-1:0]     wp_ext;
    logic [AS_W-1:0]     age_ext;
    logic [AS_W-1:0]     raddr_full;
    logic [AGE_W-1:0]    rd_addr;
    logic [AGE_W-1:0]    wp_next;
    logic [CW-1:0]       counter_next;
    logic [IDX_W-1:0]    idx_diff;
    logic                eval_next;
    logic [SAMPLE_W-1:0] mag_i;
    logic [SAMPLE_W-1:0] mag_q;
    logic [POWER_W-1:0]  rd_data;
    logic [SUM_W-1:0]    thr_sum;
    logic                in_accept;
    logic                out_accept;
    logic                out_load;
    logic                thr_start;
    logic                ram_we;
    logic                ram_re;
    thr_res_t            thr_res;

    // ------------------------------------------------------------------
    // Window geometry. A guard count above the maximum is clamped to it;
    // a training count of zero is taken as one and one above the maximum
    // is clamped.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (XW'(guard_count_reg) > XW'(MAX_GUARD))
        begin
            g = WW'(MAX_GUARD);
        end
        else
        begin
            g = WW'(guard_count_reg);
        end

        if (train_count_reg == '0)
        begin
            t = WW'(1);
        end
        else if (XW'(train_count_reg) > XW'(MAX_TRAIN))
        begin
            t = WW'(MAX_TRAIN);
        end
        else
        begin
            t = WW'(train_count_reg);
        end
    end

    assign span  = g + t;
    assign win   = WW'({span, 1'b1});
    assign two_t = J_W'({t, 1'b0});

    // ------------------------------------------------------------------
    // Read sequence over the window. Step 0 fetches the cell under test
    // (age G+T); steps 1..T fetch the leading training cells (ages
    // 0..T-1) and steps T+1..2T the lagging ones (ages G+T+G+1..2(G+T)).
    // Age 0 is the sample written most recently.
    // ------------------------------------------------------------------
    assign j_w = WW'(j_reg);

    always_comb
    begin
        if (j_reg == '0)
        begin
            age = span;
        end
        else if (j_w <= t)
        begin
            age = j_w - WW'(1);
        end
        else
        begin
            age = j_w + WW'({g, 1'b0});
        end
    end

    // Circular addressing: step back from the write pointer, wrapping once.
    assign wp_ext  = AS_W'(wp_reg);
    assign age_ext = AS_W'(age);

    always_comb
    begin
        if (wp_ext >= age_ext)
        begin
            raddr_full = wp_ext - age_ext;
        end
        else
        begin
            raddr_full = wp_ext + AS_W'(WIN_DEPTH) - age_ext;
        end
    end

    assign rd_addr = raddr_full[AGE_W-1:0];
    assign wp_next = (wp_reg == AGE_W'(WIN_DEPTH - 1)) ? '0 : wp_reg + AGE_W'(1);

    // ------------------------------------------------------------------
    // Frame bookkeeping at acceptance. The cell under test is evaluated
    // only once the whole window lies inside the current frame; the
    // counter restarts after the frame's last sample, or when the frame
    // grows to the maximum length.
    // ------------------------------------------------------------------
    assign eval_next = (CMP_W'(counter_reg) + CMP_W'(1)) >= CMP_W'(win);
    assign idx_diff  = IDX_W'(counter_reg) - IDX_W'(span);

    always_comb
    begin
        if (frame_end || (counter_reg == CW'(MAX_FRAME - 1)))
        begin
            counter_next = '0;
        end
        else
        begin
            counter_next = counter_reg + CW'(1);
        end
    end

    // Magnitudes of the two's complement components; the most negative
    // value maps onto its exact magnitude.
    assign mag_i = sample_i[SAMPLE_W-1] ? ($unsigned(~sample_i) + SAMPLE_W'(1))
                                        : $unsigned(sample_i);
    assign mag_q = sample_q[SAMPLE_W-1] ? ($unsigned(~sample_q) + SAMPLE_W'(1))
                                        : $unsigned(sample_q);

    // ------------------------------------------------------------------
    // Handshake. A new transaction is taken only from the idle state;
    // the output register frees the input side from a stalled result.
    // ------------------------------------------------------------------
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && (state_reg == ST_IDLE);
    assign out_accept = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_re    = (state_reg == ST_READ);
    assign thr_start = (state_reg == ST_LAST);

    // The last training power arrives from the RAM in the same cycle as
    // the threshold unit starts, so it is added on the way in.
    assign thr_sum = sum_reg + SUM_W'(rd_data);

    // ------------------------------------------------------------------
    // Control registers and sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_count_reg  <= GUARD_RST;
            train_count_reg  <= TRAIN_RST;
            scale_factor_reg <= SCALE_RST;
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            counter_reg      <= '0;
            j_reg            <= '0;
            eval_reg         <= 1'b0;
            acc_en_reg       <= 1'b0;
            cut_en_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GUARD: guard_count_reg  <= cfg_data[GUARD_W-1:0];
                    REG_TRAIN: train_count_reg  <= cfg_data[TRAIN_W-1:0];
                    REG_SCALE: scale_factor_reg <= cfg_data[SCALE_W-1:0];
                    default:   ;
                endcase
            end

            acc_en_reg <= ram_re && (j_reg != '0);
            cut_en_reg <= ram_re && (j_reg == '0);

            // A new result may replace one that leaves in the same cycle.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        eval_reg    <= eval_next;
                        counter_reg <= counter_next;
                        state_reg   <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    wp_reg    <= wp_next;
                    j_reg     <= '0;
                    state_reg <= eval_reg ? ST_READ : ST_IDLE;
                end
                ST_READ:
                begin
                    j_reg <= j_reg + J_W'(1);
                    if (j_reg == two_t)
                    begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (thr_res.done)
                    begin
                        state_reg <= thr_res.hit ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: squared components, reported index, training
    // sum and the cell under test.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sq_i_reg <= POWER_W'(mag_i) * POWER_W'(mag_i);
            sq_q_reg <= POWER_W'(mag_q) * POWER_W'(mag_q);
            idx_reg  <= idx_diff[INDEX_W-1:0];
            sum_reg  <= '0;
        end
        else if (acc_en_reg)
        begin
            sum_reg <= thr_sum;
        end
        if (cut_en_reg)
        begin
            cut_reg <= rd_data;
        end
        if (out_load)
        begin
            cell_index_reg <= idx_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_index = cell_index_reg;

    // ------------------------------------------------------------------
    // Power window RAM and threshold unit
    // ------------------------------------------------------------------
    cacfar_window_ram #(
        .DEPTH  (WIN_DEPTH),
        .DATA_W (POWER_W)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_next),
        .wdata (sq_i_reg + sq_q_reg),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cacfar_threshold #(
        .SUM_W (SUM_W),
        .CNT_W (J_W)
    ) u_threshold (
        .clk   (clk),
        .rst_n (rst_n),
        .start (thr_start),
        .cut   (cut_reg),
        .cnt   (two_t),
        .sum   (thr_sum),
        .scale (scale_factor_reg),
        .res   (thr_res)
    );

`ifndef ASSERT_OFF
    a_done_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        thr_res.done |-> (state_reg == ST_CMP))
        else $error("threshold result arrived outside the compare state");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result presented without a detection");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (j_reg <= two_t))
        else $error("window read sequence ran past its last cell");
`endif

endmodule

`default_nettype wire

// ===== verif/cacfar_checker.sv =====
`timescale 1ns / 1ps
// Checker for the cell-averaging CFAR detector: watches both channels and the register port.
// Depends on cacfar_pkg; holds its own copy of the detector state to predict each detection.

module cacfar_checker
    import cacfar_pkg::*;
#(
    parameter int MAX_GUARD = 8,
    parameter int MAX_TRAIN = 32,
    parameter int MAX_FRAME = 65536
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_i,
    input  wire logic signed [SAMPLE_W-1:0] sample_q,
    input  wire logic                       frame_end,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic [INDEX_W-1:0]         cell_index,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       end_check,
    output int                              pending,
    output int                              failures
);

    localparam int HIST_DEPTH   = 2 * (MAX_GUARD + MAX_TRAIN) + 1;
    localparam int CMP_W        = 80;

    logic [GUARD_W-1:0]   guard_reg;
    logic [TRAIN_W-1:0]   train_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [POWER_W-1:0]   power_hist [HIST_DEPTH];
    int unsigned          newest;
    int unsigned          frame_pos;
    logic [INDEX_W-1:0]   detections_due [$];
    logic [INDEX_W-1:0]   due_index;
    int                   mismatch_count;
    bit                   leftovers_checked;

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] cfar mismatch: %s", $time, msg);
    endtask

    function automatic logic [POWER_W-1:0] power_of(input logic signed [SAMPLE_W-1:0] si,
                                                     input logic signed [SAMPLE_W-1:0] sq);
        longint mi;
        longint mq;
        logic [POWER_W-1:0] p;
        mi = si;
        mq = sq;
        if (mi < 0) mi = -mi;
        if (mq < 0) mq = -mq;
        p = mi * mi + mq * mq;
        return p;
    endfunction

    function automatic logic [POWER_W-1:0] hist_at(input int unsigned age);
        return power_hist[(newest + HIST_DEPTH - (age % HIST_DEPTH)) % HIST_DEPTH];
    endfunction

    task automatic predict_detection(input logic signed [SAMPLE_W-1:0] si,
                                     input logic signed [SAMPLE_W-1:0] sq,
                                     input logic fe);
        int unsigned g;
        int unsigned t;
        int unsigned span;
        int unsigned width;
        int unsigned k;
        longint unsigned lead;
        longint unsigned lag;
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        g = (guard_reg > MAX_GUARD) ? MAX_GUARD : guard_reg;
        t = (train_reg == 0) ? 1 : train_reg;
        if (t > MAX_TRAIN) t = MAX_TRAIN;
        span  = g + t;
        width = 2 * span + 1;
        newest = (newest + 1) % HIST_DEPTH;
        power_hist[newest] = power_of(si, sq);
        if (frame_pos + 1 >= width) begin
            lead = 0;
            lag  = 0;
            for (k = 0; k < t; k++)
                lead += hist_at(k);
            for (k = span + g + 1; k < width; k++)
                lag += hist_at(k);
            // Power times 2T against the training sum times the Q16.16 factor, exactly.
            lhs = (CMP_W'(hist_at(span)) * CMP_W'(2 * t)) << FRAC_W;
            rhs = CMP_W'(lead + lag) * CMP_W'(scale_reg);
            if (lhs > rhs)
                detections_due = {detections_due, INDEX_W'(frame_pos - span)};
        end
        if (fe || frame_pos + 1 >= MAX_FRAME)
            frame_pos = 0;
        else
            frame_pos++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            guard_reg = GUARD_RST;
            train_reg = TRAIN_RST;
            scale_reg = SCALE_RST;
            foreach (power_hist[k])
                power_hist[k] = '0;
            newest    = 0;
            frame_pos = 0;
            detections_due.delete();
            mismatch_count    = 0;
            leftovers_checked = 1'b0;
            pending  <= 0;
            failures <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GUARD: guard_reg = cfg_data[GUARD_W-1:0];
                    REG_TRAIN: train_reg = cfg_data[TRAIN_W-1:0];
                    REG_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (detections_due.size() == 0)
                    log_mismatch($sformatf("detection at cell %0d with none due", cell_index));
                else begin
                    due_index = detections_due.pop_front();
                    if (cell_index !== due_index)
                        log_mismatch($sformatf("cell_index %0d, expected %0d",
                                               cell_index, due_index));
                end
            end
            if (in_valid && !in_stall)
                predict_detection(sample_i, sample_q, frame_end);
            if (end_check && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (detections_due.size() != 0)
                    log_mismatch($sformatf("%0d expected detections never arrived",
                                           detections_due.size()));
            end
            pending  <= detections_due.size();
            failures <= mismatch_count;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the cell-averaging CFAR detector: clock, reset, stimulus and verdict.
// Depends on cacfar_pkg, cell_averaging_cfar_detector and cacfar_checker.

module tb_top;
    import cacfar_pkg::*;

    localparam int     MAX_GUARD     = 8;
    localparam int     MAX_TRAIN     = 32;
    localparam int     MAX_FRAME     = 65536;
    localparam int     CLK_HALF      = 6;
    // Generous ceiling on the simulated time of the run.
    localparam longint LIMIT_NS      = 12_000_000;
    localparam int     HOLD_CYCLES   = 600;
    // Margin for the block to finish an evaluated cell at the largest training count.
    localparam int     SETTLE_CYCLES = 2 * MAX_TRAIN + 40;
    localparam int     PHASES        = 12;
    localparam int     PHASE_ITEMS   = 160;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0001_0000;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample_i   = '0;
    logic signed [SAMPLE_W-1:0]  sample_q   = '0;
    logic                        frame_end  = 1'b0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic [INDEX_W-1:0]          cell_index;
    logic                        cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index  = '0;
    logic [CFG_DATA_W-1:0]       cfg_data   = '0;
    logic                        end_check  = 1'b0;
    logic                        hold_req   = 1'b0;
    int                          pending;
    int                          failures;

    // Sender idling is used only by the stimulus process; the receiver's share is read by
    // the stall process at the clock edge, so it is updated with nonblocking assignments.
    int                          send_idle_pct = 0;
    int                          stall_pct     = 0;
    // Samples still to come in the current random frame; frames run on across phases,
    // so register changes also land in the middle of a frame.
    int                          frame_left    = 0;

    cell_averaging_cfar_detector #(
        .MAX_GUARD (MAX_GUARD),
        .MAX_TRAIN (MAX_TRAIN),
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_i   (sample_i),
        .sample_q   (sample_q),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_index (cell_index),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    cacfar_checker #(
        .MAX_GUARD (MAX_GUARD),
        .MAX_TRAIN (MAX_TRAIN),
        .MAX_FRAME (MAX_FRAME)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_i   (sample_i),
        .sample_q   (sample_q),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_index (cell_index),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .end_check  (end_check),
        .pending    (pending),
        .failures   (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the design hangs or a detection never turns up.
    initial
    begin
        #(LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls at the current rate. A toggle of hold_req starts a long
    // hold-off, counted here, during which the window fills and the input is stalled.
    initial
    begin
        int unsigned hold_left;
        logic        hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Mostly low-level noise, with occasional full-scale values, rail values and zeros,
    // so that powers stand clear of the noise often enough to give detections.
    function automatic logic signed [SAMPLE_W-1:0] pick_component();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        if (r < 4)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(0, 400) - 200);
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
            IDLE_SENDER:   begin send_idle_pct = 56; stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 56; end
            IDLE_BOTH:     begin send_idle_pct = 8;  stall_pct <= 8;  end
            default:       begin send_idle_pct = 0;  stall_pct <= 0;  end
        endcase
    endtask

    // One input transaction: optional idle cycles first, then the sample is held until
    // the block takes it. The stall seen at the edge is the value from before the edge.
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] si,
                                input logic signed [SAMPLE_W-1:0] sq,
                                input logic fe);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_i  <= si;
        sample_q  <= sq;
        frame_end <= fe;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_random_sample();
        if (frame_left == 0)
            frame_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
                                                      : $urandom_range(20, 160);
        offer_sample(pick_component(), pick_component(), frame_left == 1);
        frame_left--;
    endtask

    // Writes all three registers on consecutive edges; only called while the block is idle.
    task automatic program_detector(input logic [CFG_DATA_W-1:0] guard,
                                    input logic [CFG_DATA_W-1:0] train,
                                    input logic [CFG_DATA_W-1:0] scale);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GUARD;
        cfg_data  <= guard;
        @(posedge clk);
        cfg_index <= REG_TRAIN;
        cfg_data  <= train;
        @(posedge clk);
        cfg_index <= REG_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drops valid, waits for every due detection, then lets the block finish a cell that
    // produces no detection before anything else happens.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int                 p;
        int                 k;
        int                 n;
        logic [CFG_DATA_W-1:0] g;
        logic [CFG_DATA_W-1:0] t;
        logic [CFG_DATA_W-1:0] s;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Narrowest window (no guard, one training cell, factor 1.0).
        program_detector(0, 1, SCALE_ONE);
        // A frame shorter than the window gives nothing.
        offer_sample(16'sh8000, 16'sh8000, 1'b0);
        offer_sample(16'sh7FFF, 16'sh8000, 1'b1);
        // Rail values in a fresh frame: the full-scale cell at index 1 must be reported.
        offer_sample(16'sh0000, 16'sh0000, 1'b0);
        offer_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        offer_sample(16'sh8000, 16'sh0001, 1'b0);
        offer_sample(16'sh0001, 16'sh8000, 1'b1);
        settle();

        // Guard above its maximum and a training count of zero are clamped, giving a
        // window of 19. Under the largest factor a cell must dwarf its training sum to pass.
        program_detector(15, 0, SCALE_MAX);
        for (k = 0; k < 19; k++)
        begin
            if (k == 9)
                offer_sample(-16'sd1, -16'sd1, 1'b0);
            else if (k == 0 || k == 18)
                offer_sample(16'sh0000, 16'sh0000, k == 18);
            else
                offer_sample(pick_component(), pick_component(), 1'b0);
        end
        settle();

        // Random phases. The first few pin the register extremes; the rest draw
        // settings at random, mostly with short windows to keep the run quick.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    g = 0;  t = 1;  s = '0;
                end
                1:
                begin
                    g = 8;  t = 32; s = SCALE_MAX;
                end
                2:
                begin
                    g = 15; t = 63; s = $urandom_range(32'h0000_8000, 32'h0008_0000);
                end
                3:
                begin
                    g = 9;  t = 0;  s = $urandom_range(32'h0000_8000, 32'h0008_0000);
                end
                default:
                begin
                    g = $urandom_range(0, 15);
                    t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(1, 8);
                    s = ($urandom_range(0, 7) == 0) ? $urandom
                                                    : $urandom_range(32'h0000_8000,
                                                                     32'h0008_0000);
                end
            endcase
            program_detector(g, t, s);
            set_idling(idle_mode_t'(p % 4));
            // With a zero factor nearly every cell is a detection: hold the receiver off
            // while the sender keeps going, so the block backs up and stalls its input.
            if (p == 0)
                hold_req <= ~hold_req;
            for (n = 0; n < PHASE_ITEMS; n++)
                offer_random_sample();
            settle();
        end

        set_idling(IDLE_NONE);
        settle();
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
